FILE: sv/pae_pkg.sv
// pae_pkg: shared widths, request codes, cell and head structs, sine table
// for the planar arm endpoint block
// no dependencies
package pae_pkg;

    localparam int MAX_SEGS = 1024;
    localparam int IDX_W = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;
    localparam int CNT_W = $clog2(MAX_SEGS + 1);
    localparam int SEG_COUNT_W = 11;
    localparam int TYPE_W = 2;
    localparam int LEN_W = 10;
    localparam int JOINT_W = 10;
    localparam int DEG_W = 9;
    localparam int END_W = 29;
    localparam int SIN_W = 16;
    localparam int PROD_W = LEN_W + SIN_W + 1;
    localparam int Q8_SHIFT = 7;
    localparam int ROUND_BIAS = 64;
    localparam int ADDR_W = (IDX_W > JOINT_W) ? IDX_W : JOINT_W;
    localparam int CMP_W = (CNT_W > SEG_COUNT_W) ? CNT_W : SEG_COUNT_W;
    localparam int SUM_W = PROD_W + IDX_W + 1;
    localparam int ACC_W = (SUM_W > Q8_SHIFT + END_W) ? SUM_W : Q8_SHIFT + END_W;
    localparam int SEG_COUNT_RESET = 1024;

    localparam int DEG_QUARTER = 90;
    localparam int DEG_HALF = 180;
    localparam int DEG_3Q = 270;
    localparam int DEG_FULL = 360;
    localparam int SIN_MAX = 32767;
    localparam int SIN_PEAK = 32768;

    localparam logic [1:0] DRAIN_LAST = 2'd2;

    typedef enum logic [TYPE_W-1:0] {
        REQ_LOAD     = 2'd0,
        REQ_ANGLE    = 2'd1,
        REQ_STRAIGHT = 2'd2
    } req_type_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [DEG_W-1:0] ang;
    } seg_t;

    typedef struct packed {
        logic              shift;
        logic              straighten;
        logic              wr_len;
        logic              wr_ang;
        logic [ADDR_W-1:0] len_addr;
        logic [ADDR_W-1:0] ang_addr;
        logic [LEN_W-1:0]  len_data;
        logic [DEG_W-1:0]  ang_data;
    } cell_cmd_t;

    typedef struct packed {
        logic step;
        logic first;
        logic in_use;
    } head_ctl_t;

    // round(32768 * sin(d)) for d = 0..90 degrees
    localparam logic [15:0] QSIN [0:90] = '{
        16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,
        16'd2856,  16'd3425,  16'd3993,  16'd4560,  16'd5126,
        16'd5690,  16'd6252,  16'd6813,  16'd7371,  16'd7927,
        16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668,
        16'd11207, 16'd11743, 16'd12275, 16'd12803, 16'd13328,
        16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
        16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
        16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622,
        16'd21063, 16'd21498, 16'd21926, 16'd22348, 16'd22763,
        16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730,
        16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510,
        16'd26842, 16'd27166, 16'd27482, 16'd27789, 16'd28088,
        16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452,
        16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
        16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499,
        16'd31651, 16'd31795, 16'd31928, 16'd32052, 16'd32166,
        16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588,
        16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763,
        16'd32768
    };

    // q1.15 sine of a whole-degree angle, +1.0 clipped
    function automatic logic signed [SIN_W-1:0] sin_q15(input logic [DEG_W-1:0] deg);
        logic [DEG_W-1:0] idx;
        logic             neg;
        logic [15:0]      mag;
        begin
            if (deg <= DEG_W'(DEG_QUARTER))
            begin
                idx = deg;
                neg = 1'b0;
            end
            else if (deg <= DEG_W'(DEG_HALF))
            begin
                idx = DEG_W'(DEG_HALF) - deg;
                neg = 1'b0;
            end
            else if (deg <= DEG_W'(DEG_3Q))
            begin
                idx = deg - DEG_W'(DEG_HALF);
                neg = 1'b1;
            end
            else
            begin
                idx = DEG_W'(DEG_FULL) - deg;
                neg = 1'b1;
            end
            mag = (idx <= DEG_W'(DEG_QUARTER)) ? QSIN[idx[6:0]] : 16'd0;
            if (neg)
                sin_q15 = signed'(16'(-mag));
            else if (mag == 16'(SIN_PEAK))
                sin_q15 = signed'(16'(SIN_MAX));
            else
                sin_q15 = signed'(mag);
        end
    endfunction

endpackage

FILE: sv/pae_if.sv
// request, result and configuration channels of the planar arm endpoint
// depends on pae_pkg for field widths
interface pae_req_if;
    logic                           valid;
    logic                           ready;
    logic [pae_pkg::TYPE_W-1:0]     req_type;
    logic [pae_pkg::ADDR_W-1:0]     seg_index;
    logic [pae_pkg::LEN_W-1:0]      seg_len;
    logic [pae_pkg::JOINT_W-1:0]    joint_index;
    logic [pae_pkg::DEG_W-1:0]      joint_deg;

    modport source (output valid, req_type, seg_index, seg_len, joint_index, joint_deg,
                    input ready);
    modport sink (input valid, req_type, seg_index, seg_len, joint_index, joint_deg,
                  output ready);
endinterface

interface pae_res_if;
    logic                               valid;
    logic                               ready;
    logic signed [pae_pkg::END_W-1:0]   end_x;
    logic signed [pae_pkg::END_W-1:0]   end_y;
    logic                               bad_index;

    modport source (output valid, end_x, end_y, bad_index, input ready);
    modport sink (input valid, end_x, end_y, bad_index, output ready);
endinterface

interface pae_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [pae_pkg::SEG_COUNT_W-1:0]    seg_count;

    modport source (output valid, seg_count, input ready);
    modport sink (input valid, seg_count, output ready);
endinterface

FILE: sv/pae_cell.sv
// pae_cell: one segment of the ring, holding its length and joint angle
// depends on pae_pkg
module pae_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  pae_pkg::cell_cmd_t cmd,
    input  logic               len_en,
    input  logic               ang_en,
    input  pae_pkg::seg_t      nxt,
    output pae_pkg::seg_t      seg
);

    logic [pae_pkg::LEN_W-1:0] len_reg;
    logic [pae_pkg::DEG_W-1:0] ang_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.shift)
            len_reg <= nxt.len;
        else if (len_en)
            len_reg <= cmd.len_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ang_reg <= pae_pkg::DEG_W'(pae_pkg::DEG_HALF);
        else if (cmd.shift)
            ang_reg <= nxt.ang;
        else if (cmd.straighten)
            ang_reg <= pae_pkg::DEG_W'(pae_pkg::DEG_HALF);
        else if (ang_en)
            ang_reg <= cmd.ang_data;
    end

    assign seg.len = len_reg;
    assign seg.ang = ang_reg;

endmodule

FILE: sv/pae_chain.sv
// pae_chain: ring of segment cells with addressed writes, rotating towards cell 0
// depends on pae_pkg and pae_cell
module pae_chain (
    input  logic               clk,
    input  logic               rst_n,
    input  pae_pkg::cell_cmd_t cmd,
    output pae_pkg::seg_t      head
);

    pae_pkg::seg_t ring [pae_pkg::MAX_SEGS];

    genvar i;
    generate
        for (i = 0; i < pae_pkg::MAX_SEGS; i++)
        begin : g_cell
            localparam int NXT = (i + 1) % pae_pkg::MAX_SEGS;
            logic len_en;
            logic ang_en;

            assign len_en = cmd.wr_len && (cmd.len_addr == pae_pkg::ADDR_W'(i));
            assign ang_en = cmd.wr_ang && (cmd.ang_addr == pae_pkg::ADDR_W'(i));

            pae_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .cmd    (cmd),
                .len_en (len_en),
                .ang_en (ang_en),
                .nxt    (ring[NXT]),
                .seg    (ring[i])
            );
        end
    endgenerate

    assign head = ring[0];

endmodule

FILE: sv/pae_head.sv
// pae_head: angle accumulation, sine lookup, multiply and sum at the head of the ring
// depends on pae_pkg
module pae_head (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pae_pkg::head_ctl_t                ctl,
    input  pae_pkg::seg_t                     seg,
    output logic signed [pae_pkg::ACC_W-1:0]  sum_x,
    output logic signed [pae_pkg::ACC_W-1:0]  sum_y
);

    localparam int DW = pae_pkg::DEG_W;

    logic [DW-1:0]                       acc_reg;
    logic [DW:0]                         turn;
    logic [DW:0]                         wrap;
    logic [DW-1:0]                       acc_next;
    logic [DW:0]                         cos_raw;
    logic [DW-1:0]                       cos_deg;

    logic                                v1_reg, v2_reg, v3_reg;
    logic                                f1_reg, f2_reg, f3_reg;
    logic                                u1_reg, u2_reg, u3_reg;
    logic [pae_pkg::LEN_W-1:0]           len1_reg, len2_reg;
    logic signed [pae_pkg::SIN_W-1:0]    sin2_reg, cos2_reg;
    logic signed [pae_pkg::PROD_W-1:0]   px3_reg, py3_reg;
    logic signed [pae_pkg::ACC_W-1:0]    sx_reg, sy_reg;
    logic signed [pae_pkg::ACC_W-1:0]    base_x, base_y;

    // turn by (angle - 180) mod 360
    always_comb
    begin
        turn = {1'b0, seg.ang} + (DW+1)'(pae_pkg::DEG_HALF);
        if (turn >= (DW+1)'(pae_pkg::DEG_FULL))
            turn = turn - (DW+1)'(pae_pkg::DEG_FULL);
        wrap = {1'b0, acc_reg} + turn;
        if (wrap >= (DW+1)'(pae_pkg::DEG_FULL))
            wrap = wrap - (DW+1)'(pae_pkg::DEG_FULL);
        acc_next = ctl.first ? '0 : wrap[DW-1:0];

        cos_raw = {1'b0, acc_reg} + (DW+1)'(pae_pkg::DEG_QUARTER);
        if (cos_raw >= (DW+1)'(pae_pkg::DEG_FULL))
            cos_raw = cos_raw - (DW+1)'(pae_pkg::DEG_FULL);
        cos_deg = cos_raw[DW-1:0];

        base_x = f3_reg ? '0 : sx_reg;
        base_y = f3_reg ? '0 : sy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctl.step;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step)
        begin
            acc_reg  <= acc_next;
            len1_reg <= seg.len;
            f1_reg   <= ctl.first;
            u1_reg   <= ctl.in_use;
        end
        sin2_reg <= pae_pkg::sin_q15(acc_reg);
        cos2_reg <= pae_pkg::sin_q15(cos_deg);
        len2_reg <= len1_reg;
        f2_reg   <= f1_reg;
        u2_reg   <= u1_reg;
        px3_reg  <= pae_pkg::PROD_W'(signed'({1'b0, len2_reg})) * pae_pkg::PROD_W'(sin2_reg);
        py3_reg  <= pae_pkg::PROD_W'(signed'({1'b0, len2_reg})) * pae_pkg::PROD_W'(cos2_reg);
        f3_reg   <= f2_reg;
        u3_reg   <= u2_reg;
        if (v3_reg)
        begin
            sx_reg <= base_x + (u3_reg ? pae_pkg::ACC_W'(px3_reg) : '0);
            sy_reg <= base_y + (u3_reg ? pae_pkg::ACC_W'(py3_reg) : '0);
        end
    end

    assign sum_x = sx_reg;
    assign sum_y = sy_reg;

endmodule

FILE: sv/planar_arm_endpoint.sv
// planar_arm_endpoint: forward kinematics of a planar serial arm, top level
// depends on pae_pkg, pae_if, pae_chain and pae_head
//
// Segment lengths and joint angles sit in a ring of MAX_SEGS cells. Load and
// straighten requests write the ring on acceptance. An angle request writes
// its joint and then turns the ring once, one segment a cycle past the head
// unit, which accumulates the turn angle and sums length times sine and
// cosine; the endpoint is registered after the rotate, drain and finish
// states. A bad joint index skips to finish with a flagged zero result.
// New requests are taken while a result waits.
module planar_arm_endpoint (
    input  logic          clk,
    input  logic          rst_n,
    pae_req_if.sink       req,
    pae_res_if.source     res,
    pae_cfg_if.sink       cfg
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t                                 state_reg, state_next;
    logic [pae_pkg::IDX_W-1:0]              k_reg, k_next;
    logic [1:0]                             drain_reg, drain_next;
    logic [pae_pkg::CMP_W-1:0]              n_reg, n_next;
    logic                                   bad_reg, bad_next;
    logic [pae_pkg::SEG_COUNT_W-1:0]        seg_count_reg, seg_count_next;
    logic                                   out_valid_reg, out_valid_next;
    logic signed [pae_pkg::END_W-1:0]       end_x_reg, end_x_next;
    logic signed [pae_pkg::END_W-1:0]       end_y_reg, end_y_next;
    logic                                   bad_out_reg, bad_out_next;

    logic                                   accept;
    logic [pae_pkg::CMP_W-1:0]              eff_count;
    logic [pae_pkg::CMP_W-1:0]              joint_ext;
    logic                                   joint_bad;
    logic [pae_pkg::DEG_W-1:0]              deg_fold;
    pae_pkg::cell_cmd_t                     cmd;
    pae_pkg::head_ctl_t                     ctl;
    pae_pkg::seg_t                          head;
    logic signed [pae_pkg::ACC_W-1:0]       sum_x, sum_y;
    logic signed [pae_pkg::ACC_W-1:0]       rnd_x, rnd_y;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign res.valid = out_valid_reg;
    assign res.end_x = end_x_reg;
    assign res.end_y = end_y_reg;
    assign res.bad_index = bad_out_reg;

    always_comb
    begin
        if (pae_pkg::CMP_W'(seg_count_reg) > pae_pkg::CMP_W'(pae_pkg::MAX_SEGS))
            eff_count = pae_pkg::CMP_W'(pae_pkg::MAX_SEGS);
        else
            eff_count = pae_pkg::CMP_W'(seg_count_reg);
        joint_ext = pae_pkg::CMP_W'(req.joint_index);
        joint_bad = (joint_ext == '0) || (joint_ext >= eff_count);
        if (req.joint_deg >= pae_pkg::DEG_W'(pae_pkg::DEG_FULL))
            deg_fold = req.joint_deg - pae_pkg::DEG_W'(pae_pkg::DEG_FULL);
        else
            deg_fold = req.joint_deg;
    end

    always_comb
    begin
        cmd.shift      = (state_reg == ST_ROTATE);
        cmd.straighten = accept && (req.req_type == pae_pkg::REQ_STRAIGHT);
        cmd.wr_len     = accept && (req.req_type == pae_pkg::REQ_LOAD);
        cmd.wr_ang     = accept && (req.req_type == pae_pkg::REQ_ANGLE) && !joint_bad;
        cmd.len_addr   = pae_pkg::ADDR_W'(req.seg_index);
        cmd.ang_addr   = pae_pkg::ADDR_W'(req.joint_index);
        cmd.len_data   = req.seg_len;
        cmd.ang_data   = deg_fold;

        ctl.step   = (state_reg == ST_ROTATE);
        ctl.first  = (k_reg == '0);
        ctl.in_use = (pae_pkg::CMP_W'(k_reg) < n_reg);
    end

    pae_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .head  (head)
    );

    pae_head u_head (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .seg   (head),
        .sum_x (sum_x),
        .sum_y (sum_y)
    );

    // q.15 to q.8, halves rounded up; x is the negated sine sum
    assign rnd_x = pae_pkg::ACC_W'(pae_pkg::ROUND_BIAS) - sum_x;
    assign rnd_y = sum_y + pae_pkg::ACC_W'(pae_pkg::ROUND_BIAS);

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        drain_next     = drain_reg;
        n_next         = n_reg;
        bad_next       = bad_reg;
        seg_count_next = seg_count_reg;
        out_valid_next = out_valid_reg && !res.ready;
        end_x_next     = end_x_reg;
        end_y_next     = end_y_reg;
        bad_out_next   = bad_out_reg;

        if (cfg.valid && cfg.ready)
            seg_count_next = cfg.seg_count;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.req_type == pae_pkg::REQ_ANGLE))
                begin
                    bad_next = joint_bad;
                    n_next   = eff_count;
                    k_next   = '0;
                    state_next = joint_bad ? ST_FINISH : ST_ROTATE;
                end
            end
            ST_ROTATE:
            begin
                k_next = k_reg + 1'b1;
                if (k_reg == pae_pkg::IDX_W'(pae_pkg::MAX_SEGS - 1))
                begin
                    drain_next = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == pae_pkg::DRAIN_LAST)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    bad_out_next   = bad_reg;
                    end_x_next = bad_reg ? '0 : rnd_x[pae_pkg::Q8_SHIFT +: pae_pkg::END_W];
                    end_y_next = bad_reg ? '0 : rnd_y[pae_pkg::Q8_SHIFT +: pae_pkg::END_W];
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            drain_reg     <= '0;
            n_reg         <= '0;
            bad_reg       <= 1'b0;
            seg_count_reg <= pae_pkg::SEG_COUNT_W'(pae_pkg::SEG_COUNT_RESET);
            out_valid_reg <= 1'b0;
            end_x_reg     <= '0;
            end_y_reg     <= '0;
            bad_out_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            drain_reg     <= drain_next;
            n_reg         <= n_next;
            bad_reg       <= bad_next;
            seg_count_reg <= seg_count_next;
            out_valid_reg <= out_valid_next;
            end_x_reg     <= end_x_next;
            end_y_reg     <= end_y_next;
            bad_out_reg   <= bad_out_next;
        end
    end

endmodule

FILE: test/testbench.sv
// testbench: drives load, angle and straighten requests into planar_arm_endpoint
// and checks every endpoint against a behavioural model of the arm kept here
// depends on pae_pkg, pae_if and the planar_arm_endpoint rtl
module testbench;
    import pae_pkg::*;

    localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = MAX_SEGS + 16;
    localparam int PHASE_ITEMS = 45;

    typedef struct packed {
        logic [TYPE_W-1:0]  kind;
        logic [ADDR_W-1:0]  seg;
        logic [LEN_W-1:0]   len;
        logic [JOINT_W-1:0] joint;
        logic [DEG_W-1:0]   deg;
    } arm_req_t;

    typedef struct packed {
        logic signed [END_W-1:0] x;
        logic signed [END_W-1:0] y;
        logic                    bad;
    } endpoint_t;

    typedef struct {
        bit                     is_cfg;
        logic [SEG_COUNT_W-1:0] cfg_val;
        arm_req_t               rq;
        bit                     typed;
        endpoint_t              typed_res;
    } dir_row_t;

    logic clk;
    logic rst_n;

    pae_req_if req_ch();
    pae_res_if res_ch();
    pae_cfg_if cfg_ch();

    planar_arm_endpoint uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // model of the arm
    int           sin_tab [360];
    logic [LEN_W-1:0] arm_len [MAX_SEGS];
    bit           len_loaded [MAX_SEGS];
    logic [DEG_W-1:0] arm_ang [MAX_SEGS];
    int unsigned  arm_count;

    endpoint_t    endpoint_q [$];
    dir_row_t     dir_tab [$];
    int           mismatch_count = 0;
    int           req_calm = 0;
    int           res_calm = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #100000000;
        $display("FAIL planar_arm_endpoint");
        $finish;
    end

    function automatic int unsigned active_segs();
        return (arm_count > MAX_SEGS) ? MAX_SEGS : arm_count;
    endfunction

    function automatic bit predict_endpoint(input arm_req_t r, output endpoint_t e);
        int unsigned n;
        int unsigned acc;
        int unsigned deg;
        longint      sx;
        longint      sy;
        longint      vx;
        longint      vy;
        n = active_segs();
        e = '0;
        if (r.kind == REQ_LOAD)
        begin
            arm_len[r.seg] = r.len;
            len_loaded[r.seg] = 1'b1;
            return 1'b0;
        end
        if (r.kind == REQ_STRAIGHT)
        begin
            for (int i = 0; i < MAX_SEGS; i++)
                arm_ang[i] = DEG_W'(DEG_HALF);
            return 1'b0;
        end
        if (r.kind != REQ_ANGLE)
            return 1'b0;
        if (r.joint == 0 || r.joint >= n)
        begin
            e.bad = 1'b1;
            return 1'b1;
        end
        deg = r.deg;
        if (deg >= DEG_FULL)
            deg = deg - DEG_FULL;
        arm_ang[r.joint] = DEG_W'(deg);
        acc = 0;
        sx = 0;
        sy = 0;
        for (int i = 0; i < n; i++)
        begin
            if (i >= 1)
                acc = (acc + arm_ang[i] + DEG_HALF) % DEG_FULL;
            sx += longint'(arm_len[i]) * sin_tab[acc];
            sy += longint'(arm_len[i]) * sin_tab[(acc + DEG_QUARTER) % DEG_FULL];
        end
        // floor shift, so halves round towards +infinity
        vx = (64 - sx) >>> 7;
        vy = (sy + 64) >>> 7;
        e.x = END_W'(vx);
        e.y = END_W'(vy);
        return 1'b1;
    endfunction

    task automatic next_gap(inout int calm, output int gap);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0)
        begin
            calm--;
            gap = 0;
        end
        else if (r < 4)
        begin
            calm = $urandom_range(20, 60);
            gap = 0;
        end
        else if (r < 55)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
    endtask

    task automatic send_request(input arm_req_t rq, input bit typed, input endpoint_t typed_res);
        int        gap;
        endpoint_t pred;
        next_gap(req_calm, gap);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= rq.kind;
        req_ch.seg_index   <= rq.seg;
        req_ch.seg_len     <= rq.len;
        req_ch.joint_index <= rq.joint;
        req_ch.joint_deg   <= rq.deg;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (predict_endpoint(rq, pred))
            endpoint_q.push_back(typed ? typed_res : pred);
        @(negedge clk);
    endtask

    task automatic settle_block();
        while (endpoint_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_seg_count(input logic [SEG_COUNT_W-1:0] value);
        req_ch.valid <= 1'b0;
        settle_block();
        cfg_ch.valid     <= 1'b1;
        cfg_ch.seg_count <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        arm_count = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic dir_row_t req_row(input logic [TYPE_W-1:0] kind, input int seg,
                                         input int len, input int joint, input int deg);
        dir_row_t row;
        row = '{default: '0};
        row.rq.kind  = kind;
        row.rq.seg   = ADDR_W'(seg);
        row.rq.len   = LEN_W'(len);
        row.rq.joint = JOINT_W'(joint);
        row.rq.deg   = DEG_W'(deg);
        return row;
    endfunction

    function automatic dir_row_t bad_row(input int joint, input int deg);
        dir_row_t row;
        row = req_row(REQ_ANGLE, 0, 0, joint, deg);
        row.typed = 1'b1;
        row.typed_res.bad = 1'b1;
        return row;
    endfunction

    function automatic dir_row_t cfg_row(input int value);
        dir_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.cfg_val = SEG_COUNT_W'(value);
        return row;
    endfunction

    function automatic arm_req_t random_request(input int unsigned n);
        arm_req_t r;
        int       p;
        r.seg   = ADDR_W'($urandom_range(0, MAX_SEGS - 1));
        r.len   = LEN_W'($urandom_range(0, 1023));
        r.joint = JOINT_W'($urandom_range(0, 1023));
        r.deg   = DEG_W'($urandom_range(0, 511));
        p = $urandom_range(0, 99);
        if (p < 40)
        begin
            r.kind = REQ_ANGLE;
            if (n >= 2)
                r.joint = JOINT_W'($urandom_range(1, n - 1));
        end
        else if (p < 52)
            r.kind = REQ_ANGLE;
        else if (p < 82)
        begin
            r.kind = REQ_LOAD;
            if (n > 0 && $urandom_range(0, 1) == 1)
                r.seg = ADDR_W'($urandom_range(0, n - 1));
        end
        else if (p < 92)
            r.kind = REQ_STRAIGHT;
        else
            r.kind = REQ_UNUSED;
        return r;
    endfunction

    always @(posedge clk)
    begin
        endpoint_t want;
        endpoint_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.x   = res_ch.end_x;
            got.y   = res_ch.end_y;
            got.bad = res_ch.bad_index;
            if (endpoint_q.size() == 0)
            begin
                $display("%0t unexpected endpoint x %0d y %0d bad %0b",
                         $time, got.x, got.y, got.bad);
                mismatch_count++;
            end
            else
            begin
                want = endpoint_q.pop_front();
                if (got.x !== want.x)
                begin
                    $display("%0t end_x expected %0d got %0d", $time, want.x, got.x);
                    mismatch_count++;
                end
                if (got.y !== want.y)
                begin
                    $display("%0t end_y expected %0d got %0d", $time, want.y, got.y);
                    mismatch_count++;
                end
                if (got.bad !== want.bad)
                begin
                    $display("%0t bad_index expected %0b got %0b", $time, want.bad, got.bad);
                    mismatch_count++;
                end
            end
        end
    end

    // result side back-pressure
    initial
    begin
        int stall;
        stall = 0;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                next_gap(res_calm, stall);
            end
        end
    end

    initial
    begin
        int          quarter [0:90];
        int          v;
        real         deg_rad;
        int unsigned plan [12];
        int unsigned n;
        arm_req_t    rq;
        endpoint_t   none;

        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_LOAD;
        req_ch.seg_index = '0;
        req_ch.seg_len = '0;
        req_ch.joint_index = '0;
        req_ch.joint_deg = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.seg_count = '0;
        none = '0;

        // q1.15 sine table, +1.0 clipped
        deg_rad = $acos(-1.0) / 180.0;
        for (int d = 0; d <= 90; d++)
            quarter[d] = $rtoi($floor(32768.0 * $sin(d * deg_rad) + 0.5));
        for (int d = 0; d < 360; d++)
        begin
            if (d <= 90)
                v = quarter[d];
            else if (d <= 180)
                v = quarter[180 - d];
            else if (d <= 270)
                v = -quarter[d - 180];
            else
                v = -quarter[360 - d];
            if (v > 32767)
                v = 32767;
            sin_tab[d] = v;
        end

        arm_count = SEG_COUNT_RESET;
        for (int i = 0; i < MAX_SEGS; i++)
        begin
            arm_ang[i] = DEG_W'(DEG_HALF);
            len_loaded[i] = 1'b0;
            arm_len[i] = '0;
        end

        dir_tab.push_back(bad_row(0, 90));
        dir_tab.push_back(req_row(REQ_STRAIGHT, 0, 0, 0, 0));
        dir_tab.push_back(req_row(REQ_UNUSED, 1023, 1023, 1023, 511));
        dir_tab.push_back(cfg_row(0));
        dir_tab.push_back(bad_row(1, 0));
        dir_tab.push_back(cfg_row(1));
        dir_tab.push_back(bad_row(1, 180));
        dir_tab.push_back(cfg_row(4));
        dir_tab.push_back(req_row(REQ_LOAD, 0, 1023, 0, 0));
        dir_tab.push_back(req_row(REQ_LOAD, 1, 0, 0, 0));
        dir_tab.push_back(req_row(REQ_LOAD, 2, 1, 0, 0));
        dir_tab.push_back(req_row(REQ_LOAD, 3, 1023, 0, 0));
        dir_tab.push_back(req_row(REQ_LOAD, 1023, 1023, 0, 0));
        dir_tab.push_back(req_row(REQ_ANGLE, 0, 0, 1, 180));
        dir_tab.push_back(req_row(REQ_ANGLE, 0, 0, 2, 0));
        dir_tab.push_back(req_row(REQ_ANGLE, 0, 0, 3, 359));
        dir_tab.push_back(req_row(REQ_ANGLE, 0, 0, 3, 511));
        dir_tab.push_back(req_row(REQ_ANGLE, 0, 0, 2, 360));
        dir_tab.push_back(bad_row(4, 90));
        dir_tab.push_back(bad_row(1023, 511));
        dir_tab.push_back(req_row(REQ_STRAIGHT, 1023, 1023, 1023, 511));
        dir_tab.push_back(req_row(REQ_ANGLE, 0, 0, 1, 90));
        dir_tab.push_back(req_row(REQ_UNUSED, 0, 0, 0, 0));
        dir_tab.push_back(req_row(REQ_ANGLE, 0, 0, 3, 270));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_tab[k])
        begin
            if (dir_tab[k].is_cfg)
                write_seg_count(dir_tab[k].cfg_val);
            else
                send_request(dir_tab[k].rq, dir_tab[k].typed, dir_tab[k].typed_res);
        end

        plan = '{2, $urandom_range(3, 40), 2047, 0, $urandom_range(2, 16), 1,
                 $urandom_range(41, 400), 1024, $urandom_range(2, 64), 1025,
                 $urandom_range(2, 8), 64};
        foreach (plan[p])
        begin
            write_seg_count(SEG_COUNT_W'(plan[p]));
            n = active_segs();
            // every length in the active chain must be loaded before an angle request
            for (int i = 0; i < n; i++)
            begin
                if (!len_loaded[i])
                begin
                    rq = random_request(n);
                    rq.kind = REQ_LOAD;
                    rq.seg = ADDR_W'(i);
                    send_request(rq, 1'b0, none);
                end
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_request(random_request(n), 1'b0, none);
        end

        req_ch.valid <= 1'b0;
        settle_block();
        if (mismatch_count == 0)
            $display("PASS planar_arm_endpoint");
        else
            $display("FAIL planar_arm_endpoint");
        $finish;
    end

endmodule

FILE: planar_arm_endpoint.f
sv/pae_pkg.sv
sv/pae_if.sv
sv/pae_cell.sv
sv/pae_chain.sv
sv/pae_head.sv
sv/planar_arm_endpoint.sv
test/testbench.sv
